// ----- sv/psc_pkg.sv -----
// psc_pkg: widths, fixed-point constants and stage payload types of the
// parabolic sine / cosine pipeline. No dependencies.
`default_nettype none

package psc_pkg;

   // port field widths
   localparam int ANGLE_W = 22;
   localparam int VALUE_W = 18;
   localparam int DEF_ANGLE_FRAC_BITS = 16;

   // internal angle and amplitude format is Q28
   localparam int WORK_BITS = 28;
   localparam int OUT_FRAC_BITS = 16;
   localparam int OUT_SHIFT = WORK_BITS - OUT_FRAC_BITS;

   localparam longint Q_PI = 64'sd843314857;
   localparam longint Q_TWO_PI = 64'sd1686629713;
   localparam longint Q_HALF_PI = 64'sd421657428;
   localparam longint Q_B = 64'sd341782638;
   localparam longint Q_C = 64'sd108792793;
   localparam longint Q_P = 64'sd60397978;
   localparam longint Q_ONE = 64'sd1 <<< WORK_BITS;
   localparam longint Q_HALF = 64'sd1 <<< (WORK_BITS - 1);
   localparam int TWO_PI_W = 31;

   // quotient estimate by reciprocal multiply
   localparam int RECIP_SHIFT = 32;
   localparam int QUOT_W = 9;

   // datapath widths
   localparam int X_W = 30;
   localparam int X2_W = 32;
   localparam int BX_W = 59;
   localparam int CX_W = 59;
   localparam int ACC_W = 61;
   localparam int Y_W = 29;
   localparam int DIF_W = 27;
   localparam int PD_W = 53;

   // reduced angle in [0, pi) and the sign of the result
   typedef struct packed {
      logic [X_W-1:0] x;
      logic neg;
   } red_type;

   // parabola after saturation, scaled correction term and sign
   typedef struct packed {
      logic [Y_W-1:0] y;
      logic [PD_W-1:0] pd;
      logic neg;
   } poly_type;

endpackage

`default_nettype wire

// ----- sv/psc_reduce.sv -----
// psc_reduce: three-stage angle reduction, cosine offset and wrap modulo
// two pi, then fold into [0, pi). Depends on psc_pkg.
`default_nettype none

module psc_reduce
   import psc_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   output logic up_ready,
   input  logic up_cmd,
   input  logic signed [ANGLE_W-1:0] up_angle,
   output logic dn_valid,
   input  logic dn_ready,
   output red_type dn_red
);

   localparam int SHIFT = WORK_BITS - ANGLE_FRAC_BITS;
   localparam int A_W = ((ANGLE_W + SHIFT > TWO_PI_W) ? ANGLE_W + SHIFT : TWO_PI_W) + 2;
   localparam int P_W = RECIP_SHIFT + QUOT_W;
   localparam int D_W = 48;
   localparam int R_W = TWO_PI_W + 2;
   localparam logic [63:0] TWO_PI_64 = 64'(Q_TWO_PI);
   localparam logic [63:0] RECIP_K =
      ((64'd1 << (RECIP_SHIFT + SHIFT)) + TWO_PI_64 / 2) / TWO_PI_64;
   localparam logic signed [P_W-1:0] RECIP_K_P = $signed(P_W'(RECIP_K));
   localparam logic signed [A_W-1:0] HALF_PI_A = A_W'(Q_HALF_PI);
   localparam logic signed [A_W-1:0] ZERO_A = '0;
   localparam logic signed [D_W-1:0] TWO_PI_D = D_W'(Q_TWO_PI);
   localparam logic signed [R_W-1:0] TWO_PI_R = R_W'(Q_TWO_PI);
   localparam logic signed [R_W-1:0] PI_R = R_W'(Q_PI);
   localparam logic signed [R_W-1:0] ZERO_R = '0;

   logic [2:0] valid_ff, valid_in, en;

   logic signed [P_W-1:0] angle_p, prod;
   logic signed [A_W-1:0] a_ff, a_in;
   logic signed [QUOT_W-1:0] q_ff, q_in;
   logic signed [D_W-1:0] r0_full;
   logic signed [R_W-1:0] r0_ff, r0_in, r1;
   red_type red_ff, red_in;

   // a stage moves when it is empty or the next one moves
   always_comb begin
      en[2] = !valid_ff[2] || dn_ready;
      en[1] = !valid_ff[1] || en[2];
      en[0] = !valid_ff[0] || en[1];
      valid_in[0] = en[0] ? up_valid : valid_ff[0];
      valid_in[1] = en[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = en[2] ? valid_ff[1] : valid_ff[2];
   end

   assign up_ready = en[0];
   assign dn_valid = valid_ff[2];
   assign dn_red = red_ff;

   // stage 1: angle to Q28 plus offset, and turn count estimate from the raw angle
   assign angle_p = P_W'(up_angle);
   assign prod = angle_p * RECIP_K_P;
   assign q_in = prod[P_W-1 -: QUOT_W];
   assign a_in = (A_W'(up_angle) <<< SHIFT) + (up_cmd ? HALF_PI_A : ZERO_A);

   // stage 2: remove whole turns, estimate may be one off either way
   assign r0_full = D_W'(a_ff) - D_W'(q_ff) * TWO_PI_D;
   assign r0_in = r0_full[R_W-1:0];

   // stage 3: fix the estimate, then fold the upper half turn
   always_comb begin
      if (r0_ff < ZERO_R) begin
         r1 = r0_ff + TWO_PI_R;
      end else if (r0_ff >= TWO_PI_R) begin
         r1 = r0_ff - TWO_PI_R;
      end else begin
         r1 = r0_ff;
      end
      if (r1 >= PI_R) begin
         red_in.x = X_W'(r1 - PI_R);
         red_in.neg = 1'b1;
      end else begin
         red_in.x = X_W'(r1);
         red_in.neg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_ff <= a_in;
         q_ff <= q_in;
      end
      if (en[1]) begin
         r0_ff <= r0_in;
      end
      if (en[2]) begin
         red_ff <= red_in;
      end
   end

   a_turn_estimate: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (r0_in >= -TWO_PI_R && r0_in < (TWO_PI_R <<< 1)))
      else $error("turn estimate off by more than one");

   a_reduced_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (red_ff.x < X_W'(Q_PI)))
      else $error("reduced angle not below pi");

endmodule

`default_nettype wire

// ----- sv/psc_poly.sv -----
// psc_poly: five-stage parabola y = B*x - C*x*x with clamp and saturation,
// then the scaled correction P*(y - y*y). Depends on psc_pkg.
`default_nettype none

module psc_poly
   import psc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   output logic up_ready,
   input  red_type up_red,
   output logic dn_valid,
   input  logic dn_ready,
   output poly_type dn_poly
);

   localparam int STAGES = 5;
   localparam logic [2*X_W-1:0] HALF_XX = (2*X_W)'(Q_HALF);
   localparam logic [2*Y_W-1:0] HALF_YY = (2*Y_W)'(Q_HALF);
   localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(Q_HALF);
   localparam logic [ACC_W-WORK_BITS-2:0] ONE_Y = (ACC_W-WORK_BITS-1)'(Q_ONE);

   logic [STAGES-1:0] valid_ff, valid_in, en;

   logic [2*X_W-1:0] xx, xx_rnd;
   logic [X2_W-1:0] x2_ff, x2_in;
   logic [BX_W-1:0] bx_a_ff, bx_in, bx_b_ff;
   logic [CX_W-1:0] cx_ff, cx_in;
   logic signed [ACC_W-1:0] acc;
   logic [ACC_W-WORK_BITS-2:0] y_raw;
   logic [Y_W-1:0] y_c_ff, y_in, y_d_ff, y_e_ff, y2, dif_full;
   logic [2*Y_W-1:0] yy, yy_rnd;
   logic [DIF_W-1:0] dif_ff, dif_in;
   logic [PD_W-1:0] pd_ff, pd_in;
   logic [STAGES-1:0] neg_ff;

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || dn_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = en[0] ? up_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   assign up_ready = en[0];
   assign dn_valid = valid_ff[STAGES-1];
   assign dn_poly.y = y_e_ff;
   assign dn_poly.pd = pd_ff;
   assign dn_poly.neg = neg_ff[STAGES-1];

   // stage a: x squared (rounded to Q28) and B*x side by side
   assign xx = (2*X_W)'(up_red.x) * (2*X_W)'(up_red.x);
   assign xx_rnd = xx + HALF_XX;
   assign x2_in = xx_rnd[WORK_BITS +: X2_W];
   assign bx_in = BX_W'(Q_B) * BX_W'(up_red.x);

   // stage b
   assign cx_in = CX_W'(Q_C) * CX_W'(x2_ff);

   // stage c: clamp below zero, saturate at one
   assign acc = $signed(ACC_W'(bx_b_ff)) - $signed(ACC_W'(cx_ff)) + HALF_ACC;
   assign y_raw = acc[ACC_W-1] ? '0 : acc[ACC_W-2:WORK_BITS];
   assign y_in = (y_raw > ONE_Y) ? Y_W'(Q_ONE) : y_raw[Y_W-1:0];

   // stage d: y - y*y, never negative since y is at most one
   assign yy = (2*Y_W)'(y_c_ff) * (2*Y_W)'(y_c_ff);
   assign yy_rnd = yy + HALF_YY;
   assign y2 = yy_rnd[WORK_BITS +: Y_W];
   assign dif_full = y_c_ff - y2;
   assign dif_in = dif_full[DIF_W-1:0];

   // stage e
   assign pd_in = PD_W'(Q_P) * PD_W'(dif_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x2_ff <= x2_in;
         bx_a_ff <= bx_in;
         neg_ff[0] <= up_red.neg;
      end
      if (en[1]) begin
         cx_ff <= cx_in;
         bx_b_ff <= bx_a_ff;
         neg_ff[1] <= neg_ff[0];
      end
      if (en[2]) begin
         y_c_ff <= y_in;
         neg_ff[2] <= neg_ff[1];
      end
      if (en[3]) begin
         y_d_ff <= y_c_ff;
         dif_ff <= dif_in;
         neg_ff[3] <= neg_ff[2];
      end
      if (en[4]) begin
         y_e_ff <= y_d_ff;
         pd_ff <= pd_in;
         neg_ff[4] <= neg_ff[3];
      end
   end

   a_parabola_saturated: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (y_c_ff <= Y_W'(Q_ONE)))
      else $error("parabola above one");

   a_square_below_y: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (y2 <= y_c_ff))
      else $error("y squared above y");

endmodule

`default_nettype wire

// ----- sv/parabolic_sine_cosine.sv -----
// parabolic_sine_cosine: fast sine / cosine, top level with the final
// rounding, sign and output register. Depends on psc_pkg, psc_reduce, psc_poly.
//
// Usage:
//   req channel: req_cmd (0 sine, 1 cosine) and req_angle, signed radians with
//   ANGLE_FRAC_BITS fraction bits, taken when req_valid and req_ready are high.
//   rsp channel: rsp_value, signed Q1.16 within plus or minus one, one word
//   for each request word, in order, taken when rsp_valid and rsp_ready are high.
//   Pipeline: nine register stages lie between req_angle and rsp_value.
//   Throughput: one word per cycle when nothing stalls; no state between words.
//   Stall: each stage advances when it is empty or the stage after it advances,
//   so bubbles close up and req_ready stays high until all nine stages hold
//   words while rsp_ready is low; nothing is dropped or repeated.
//   The longest paths are the 30 x 30 multiplier of the x squared stage and the
//   quotient estimate multiplier of the angle wrap.
//   Reset: synchronous, clears all valid bits; no clearing pass is needed.
`default_nettype none

module parabolic_sine_cosine
   import psc_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_cmd,
   input  logic signed [ANGLE_W-1:0] req_angle,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value
);

   localparam logic [PD_W-1:0] HALF_PD = PD_W'(Q_HALF);
   localparam logic [Y_W-1:0] HALF_OUT = Y_W'(64'd1 << (OUT_SHIFT - 1));
   localparam int V_W = Y_W - OUT_SHIFT;

   logic red_valid, red_ready;
   red_type red;
   logic poly_valid, poly_ready;
   poly_type poly;

   logic [PD_W-1:0] corr_sum;
   logic [Y_W-1:0] z, z_rnd;
   logic [V_W-1:0] v;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic valid_ff, valid_in, en_out;

   psc_reduce #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_reduce (
      .clock(clock),
      .reset(reset),
      .up_valid(req_valid),
      .up_ready(req_ready),
      .up_cmd(req_cmd),
      .up_angle(req_angle),
      .dn_valid(red_valid),
      .dn_ready(red_ready),
      .dn_red(red)
   );

   psc_poly u_poly (
      .clock(clock),
      .reset(reset),
      .up_valid(red_valid),
      .up_ready(red_ready),
      .up_red(red),
      .dn_valid(poly_valid),
      .dn_ready(poly_ready),
      .dn_poly(poly)
   );

   // z = y - round(P*(y - y*y)), then round to Q16 and apply the sign
   assign corr_sum = poly.pd + HALF_PD;
   assign z = poly.y - Y_W'(corr_sum[PD_W-1:WORK_BITS]);
   assign z_rnd = z + HALF_OUT;
   assign v = z_rnd[Y_W-1:OUT_SHIFT];
   assign value_in = poly.neg ? -$signed(VALUE_W'(v)) : $signed(VALUE_W'(v));

   assign en_out = !valid_ff || rsp_ready;
   assign poly_ready = en_out;
   assign valid_in = en_out ? poly_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         value_ff <= value_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value <= 18'sd65536 && rsp_value >= -18'sd65536))
      else $error("result outside plus or minus one");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("word present right after reset");

endmodule

`default_nettype wire
